// ----- hdl/lobu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lobu_pkg
// Shared types and constants of the limit order book update block.
// ----------------------------------------------------------------------------
package lobu_pkg;

    localparam int MAX_ORDERS_DEF = 1024;
    localparam int MAX_LEVELS_DEF = 256;

    localparam int PLACE_W = 49;   // locate(16) ask(1) price(32)
    localparam int SUM_W   = 42;
    localparam int CNT_OUT_W = 11;
    localparam int IN_W    = 224;
    localparam int OUT_W   = 152;

    localparam logic [7:0] SIDE_BUY  = 8'h42;
    localparam logic [7:0] SIDE_SELL = 8'h53;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_REDUCE  = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_REPLACE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_DUP_REF  = 3'd1,
        STS_BAD_SIDE = 3'd2,
        STS_UNKNOWN  = 3'd3,
        STS_OVER     = 3'd4,
        STS_FULL     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OSCAN,
        S_LSCAN,
        S_EXEC,
        S_EXEC2,
        S_BSCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                live;
        logic [63:0]         key;
        logic [PLACE_W-1:0]  place;
        logic [31:0]         rem;
    } ord_word_t;

endpackage : lobu_pkg
`default_nettype wire

// ----- hdl/limit_order_book_update_top.sv -----
`default_nettype none
// sequence: an input transfer is followed by one pass over the order table and two
// passes over the level table, one entry a cycle, before m_tvalid is set
// input: s_tready is high only between items; a new item is not taken before the last
// one has reached the output register
// reset: after rst_n a clearing pass over the order table empties it, s_tready stays
// low meanwhile; level valid bits and the live count clear at once
// ----------------------------------------------------------------------------
// limit_order_book_update_top
// Order table and price level table kept from feed commands, with a small
// sequencer that scans the tables through one registered read port each.
// ----------------------------------------------------------------------------
module limit_order_book_update_top
    import lobu_pkg::*;
#(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // command, stock_locate, orig_ref, new_ref, side_code, share_qty, limit_price
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // status, affected_stock, bid_valid, best_bid_price, ask_valid,
    // best_ask_price, level_shares, level_orders, live_total
    output logic [OUT_W-1:0]       m_tdata
);

    localparam int OW  = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CW  = $clog2(MAX_ORDERS + 1);
    localparam int SCW = $clog2(((MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS) + 1);

    // memories
    ord_word_t           ord_mem [MAX_ORDERS];
    logic [PLACE_W-1:0]  lvl_key_mem [MAX_LEVELS];
    logic [SUM_W-1:0]    lvl_sum_mem [MAX_LEVELS];
    logic [CW-1:0]       lvl_tally_mem [MAX_LEVELS];

    ord_word_t           ord_rd;
    logic [PLACE_W-1:0]  lvl_key_rd;
    logic [SUM_W-1:0]    lvl_sum_rd;
    logic [CW-1:0]       lvl_tally_rd;

    logic                ord_we;
    logic [OW-1:0]       ord_waddr;
    ord_word_t           ord_wdata;
    logic                lvl_we;
    logic [LW-1:0]       lvl_waddr;
    logic [PLACE_W-1:0]  lvl_wkey;
    logic [SUM_W-1:0]    lvl_wsum;
    logic [CW-1:0]       lvl_wtally;
    logic [OW-1:0]       ord_raddr;
    logic [LW-1:0]       lvl_raddr;

    // registers
    state_t              state_reg, state_next;
    logic [SCW-1:0]      cnt_reg, cnt_next;
    cmd_t                cmd_reg, cmd_next;
    logic [15:0]         stock_reg, stock_next;
    logic [63:0]         ref_reg, ref_next;
    logic [63:0]         nref_reg, nref_next;
    logic [7:0]          side_reg, side_next;
    logic [31:0]         qty_reg, qty_next;
    logic [31:0]         price_reg, price_next;

    logic                o_found_reg, o_found_next;
    logic [OW-1:0]       o_idx_reg, o_idx_next;
    logic [PLACE_W-1:0]  o_place_reg, o_place_next;
    logic [31:0]         o_rem_reg, o_rem_next;
    logic                oth_found_reg, oth_found_next;
    logic [OW-1:0]       oth_idx_reg, oth_idx_next;
    logic                free_found_reg, free_found_next;
    logic [OW-1:0]       free_idx_reg, free_idx_next;

    logic                old_found_reg, old_found_next;
    logic [LW-1:0]       old_idx_reg, old_idx_next;
    logic [SUM_W-1:0]    old_sum_reg, old_sum_next;
    logic [CW-1:0]       old_tally_reg, old_tally_next;
    logic                new_found_reg, new_found_next;
    logic [LW-1:0]       new_idx_reg, new_idx_next;
    logic [SUM_W-1:0]    new_sum_reg, new_sum_next;
    logic [CW-1:0]       new_tally_reg, new_tally_next;
    logic                spare_found_reg, spare_found_next;
    logic [LW-1:0]       spare_idx_reg, spare_idx_next;

    status_t             status_reg, status_next;
    logic [15:0]         aff_reg, aff_next;
    logic                have_reg, have_next;
    logic [SUM_W-1:0]    ls_reg, ls_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic                l2_do_reg, l2_do_next;
    logic [LW-1:0]       l2_idx_reg, l2_idx_next;
    logic [PLACE_W-1:0]  l2_key_reg, l2_key_next;
    logic [SUM_W-1:0]    l2_sum_reg, l2_sum_next;
    logic [CW-1:0]       l2_tally_reg, l2_tally_next;

    logic                bv_reg, bv_next;
    logic [31:0]         bb_reg, bb_next;
    logic                av_reg, av_next;
    logic [31:0]         ba_reg, ba_next;
    logic [CW-1:0]       live_count_reg, live_count_next;
    logic [MAX_LEVELS-1:0] level_live_reg, level_live_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    // derived values
    logic [SCW-1:0]      cnt_m1;
    logic [OW-1:0]       pidx_o;
    logic [LW-1:0]       pidx_l;
    logic [PLACE_W-1:0]  new_place;
    logic [SUM_W-1:0]    qty42, rem42;
    logic [31:0]         red_rem;
    logic [SUM_W-1:0]    red_sum, drop_sum, rep_sum, ins_sum;
    logic [CW-1:0]       drop_tally, ins_tally;
    logic [LW-1:0]       ins_idx;
    logic                same_place;
    logic                room;
    logic [CW+CNT_OUT_W-1:0] lo_ext, open_ext;

    assign cnt_m1   = cnt_reg - 1'b1;
    assign pidx_o   = cnt_m1[OW-1:0];
    assign pidx_l   = cnt_m1[LW-1:0];
    assign ord_raddr = cnt_reg[OW-1:0];
    assign lvl_raddr = cnt_reg[LW-1:0];

    assign new_place = (cmd_reg == CMD_ADD) ?
                       {stock_reg, (side_reg == SIDE_SELL), price_reg} :
                       {o_place_reg[PLACE_W-1:32], price_reg};
    assign qty42      = {10'b0, qty_reg};
    assign rem42      = {10'b0, o_rem_reg};
    assign red_rem    = o_rem_reg - qty_reg;
    assign red_sum    = old_sum_reg - qty42;
    assign drop_sum   = old_sum_reg - rem42;
    assign drop_tally = old_tally_reg - 1'b1;
    assign rep_sum    = old_sum_reg - rem42 + qty42;
    assign ins_sum    = new_found_reg ? (new_sum_reg + qty42) : qty42;
    assign ins_tally  = new_found_reg ? (new_tally_reg + 1'b1) : CW'(1);
    // with no free level slot the old level is freed by the removal
    assign ins_idx    = new_found_reg ? new_idx_reg :
                        (spare_found_reg ? spare_idx_reg : old_idx_reg);
    assign same_place = (price_reg == o_place_reg[31:0]);
    assign room       = new_found_reg || spare_found_reg ||
                        (old_found_reg && (old_tally_reg == CW'(1)));
    assign lo_ext     = {{CNT_OUT_W{1'b0}}, lo_reg};
    assign open_ext   = {{CNT_OUT_W{1'b0}}, live_count_reg};

    // memories, registered read
    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rd <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_key_mem[lvl_waddr]   <= lvl_wkey;
            lvl_sum_mem[lvl_waddr]   <= lvl_wsum;
            lvl_tally_mem[lvl_waddr] <= lvl_wtally;
        end
        lvl_key_rd   <= lvl_key_mem[lvl_raddr];
        lvl_sum_rd   <= lvl_sum_mem[lvl_raddr];
        lvl_tally_rd <= lvl_tally_mem[lvl_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            cmd_reg         <= CMD_ADD;
            stock_reg       <= '0;
            ref_reg         <= '0;
            nref_reg        <= '0;
            side_reg        <= '0;
            qty_reg         <= '0;
            price_reg       <= '0;
            o_found_reg     <= 1'b0;
            o_idx_reg       <= '0;
            o_place_reg     <= '0;
            o_rem_reg       <= '0;
            oth_found_reg   <= 1'b0;
            oth_idx_reg     <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            old_found_reg   <= 1'b0;
            old_idx_reg     <= '0;
            old_sum_reg     <= '0;
            old_tally_reg   <= '0;
            new_found_reg   <= 1'b0;
            new_idx_reg     <= '0;
            new_sum_reg     <= '0;
            new_tally_reg   <= '0;
            spare_found_reg <= 1'b0;
            spare_idx_reg   <= '0;
            status_reg      <= STS_OK;
            aff_reg         <= '0;
            have_reg        <= 1'b0;
            ls_reg          <= '0;
            lo_reg          <= '0;
            l2_do_reg       <= 1'b0;
            l2_idx_reg      <= '0;
            l2_key_reg      <= '0;
            l2_sum_reg      <= '0;
            l2_tally_reg    <= '0;
            bv_reg          <= 1'b0;
            bb_reg          <= '0;
            av_reg          <= 1'b0;
            ba_reg          <= '0;
            live_count_reg  <= '0;
            level_live_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            cmd_reg         <= cmd_next;
            stock_reg       <= stock_next;
            ref_reg         <= ref_next;
            nref_reg        <= nref_next;
            side_reg        <= side_next;
            qty_reg         <= qty_next;
            price_reg       <= price_next;
            o_found_reg     <= o_found_next;
            o_idx_reg       <= o_idx_next;
            o_place_reg     <= o_place_next;
            o_rem_reg       <= o_rem_next;
            oth_found_reg   <= oth_found_next;
            oth_idx_reg     <= oth_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            old_found_reg   <= old_found_next;
            old_idx_reg     <= old_idx_next;
            old_sum_reg     <= old_sum_next;
            old_tally_reg   <= old_tally_next;
            new_found_reg   <= new_found_next;
            new_idx_reg     <= new_idx_next;
            new_sum_reg     <= new_sum_next;
            new_tally_reg   <= new_tally_next;
            spare_found_reg <= spare_found_next;
            spare_idx_reg   <= spare_idx_next;
            status_reg      <= status_next;
            aff_reg         <= aff_next;
            have_reg        <= have_next;
            ls_reg          <= ls_next;
            lo_reg          <= lo_next;
            l2_do_reg       <= l2_do_next;
            l2_idx_reg      <= l2_idx_next;
            l2_key_reg      <= l2_key_next;
            l2_sum_reg      <= l2_sum_next;
            l2_tally_reg    <= l2_tally_next;
            bv_reg          <= bv_next;
            bb_reg          <= bb_next;
            av_reg          <= av_next;
            ba_reg          <= ba_next;
            live_count_reg  <= live_count_next;
            level_live_reg  <= level_live_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmd_next         = cmd_reg;
        stock_next       = stock_reg;
        ref_next         = ref_reg;
        nref_next        = nref_reg;
        side_next        = side_reg;
        qty_next         = qty_reg;
        price_next       = price_reg;
        o_found_next     = o_found_reg;
        o_idx_next       = o_idx_reg;
        o_place_next     = o_place_reg;
        o_rem_next       = o_rem_reg;
        oth_found_next   = oth_found_reg;
        oth_idx_next     = oth_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        old_found_next   = old_found_reg;
        old_idx_next     = old_idx_reg;
        old_sum_next     = old_sum_reg;
        old_tally_next   = old_tally_reg;
        new_found_next   = new_found_reg;
        new_idx_next     = new_idx_reg;
        new_sum_next     = new_sum_reg;
        new_tally_next   = new_tally_reg;
        spare_found_next = spare_found_reg;
        spare_idx_next   = spare_idx_reg;
        status_next      = status_reg;
        aff_next         = aff_reg;
        have_next        = have_reg;
        ls_next          = ls_reg;
        lo_next          = lo_reg;
        l2_do_next       = l2_do_reg;
        l2_idx_next      = l2_idx_reg;
        l2_key_next      = l2_key_reg;
        l2_sum_next      = l2_sum_reg;
        l2_tally_next    = l2_tally_reg;
        bv_next          = bv_reg;
        bb_next          = bb_reg;
        av_next          = av_reg;
        ba_next          = ba_reg;
        live_count_next  = live_count_reg;
        level_live_next  = level_live_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        ord_we     = 1'b0;
        ord_waddr  = o_idx_reg;
        ord_wdata  = '0;
        lvl_we     = 1'b0;
        lvl_waddr  = old_idx_reg;
        lvl_wkey   = o_place_reg;
        lvl_wsum   = drop_sum;
        lvl_wtally = drop_tally;

        case (state_reg)
            S_CLEAR:
            begin
                ord_we    = 1'b1;
                ord_waddr = cnt_reg[OW-1:0];
                if (cnt_reg == SCW'(MAX_ORDERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next         = cmd_t'(s_tdata[1:0]);
                    stock_next       = s_tdata[17:2];
                    ref_next         = s_tdata[81:18];
                    nref_next        = s_tdata[145:82];
                    side_next        = s_tdata[153:146];
                    qty_next         = s_tdata[185:154];
                    price_next       = s_tdata[217:186];
                    o_found_next     = 1'b0;
                    oth_found_next   = 1'b0;
                    free_found_next  = 1'b0;
                    old_found_next   = 1'b0;
                    new_found_next   = 1'b0;
                    spare_found_next = 1'b0;
                    l2_do_next       = 1'b0;
                    cnt_next         = '0;
                    state_next       = S_OSCAN;
                end
            end

            S_OSCAN:
            begin
                // entry cnt-1 arrives from the read issued last cycle
                if (cnt_reg != '0)
                begin
                    if (ord_rd.live && (ord_rd.key == ref_reg) && !o_found_reg)
                    begin
                        o_found_next = 1'b1;
                        o_idx_next   = pidx_o;
                        o_place_next = ord_rd.place;
                        o_rem_next   = ord_rd.rem;
                    end
                    if (ord_rd.live && (ord_rd.key == nref_reg))
                    begin
                        oth_found_next = 1'b1;
                        oth_idx_next   = pidx_o;
                    end
                    if (!ord_rd.live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_o;
                    end
                end
                if (cnt_reg == SCW'(MAX_ORDERS))
                begin
                    cnt_next   = '0;
                    state_next = S_LSCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_LSCAN:
            begin
                if (cnt_reg != '0)
                begin
                    if (level_live_reg[pidx_l] && (lvl_key_rd == o_place_reg) &&
                        (cmd_reg != CMD_ADD) && o_found_reg)
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = pidx_l;
                        old_sum_next   = lvl_sum_rd;
                        old_tally_next = lvl_tally_rd;
                    end
                    if (level_live_reg[pidx_l] && (lvl_key_rd == new_place))
                    begin
                        new_found_next = 1'b1;
                        new_idx_next   = pidx_l;
                        new_sum_next   = lvl_sum_rd;
                        new_tally_next = lvl_tally_rd;
                    end
                    if (!level_live_reg[pidx_l] && !spare_found_reg)
                    begin
                        spare_found_next = 1'b1;
                        spare_idx_next   = pidx_l;
                    end
                end
                if (cnt_reg == SCW'(MAX_LEVELS))
                begin
                    cnt_next   = '0;
                    state_next = S_EXEC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_EXEC:
            begin
                status_next = STS_OK;
                ls_next     = '0;
                lo_next     = '0;
                aff_next    = o_place_reg[PLACE_W-1:33];
                have_next   = 1'b1;
                l2_key_next   = new_place;
                l2_idx_next   = ins_idx;
                l2_sum_next   = ins_sum;
                l2_tally_next = ins_tally;
                state_next  = S_EXEC2;
                if (cmd_reg == CMD_ADD)
                begin
                    aff_next = stock_reg;
                    if (o_found_reg)
                    begin
                        status_next = STS_DUP_REF;
                    end
                    else if (!(side_reg inside {SIDE_BUY, SIDE_SELL}))
                    begin
                        status_next = STS_BAD_SIDE;
                    end
                    else if (!free_found_reg || (!new_found_reg && !spare_found_reg))
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        ord_we          = 1'b1;
                        ord_waddr       = free_idx_reg;
                        ord_wdata       = '{live: 1'b1, key: ref_reg, place: new_place,
                                            rem: qty_reg};
                        live_count_next = live_count_reg + 1'b1;
                        l2_do_next      = 1'b1;
                        ls_next         = ins_sum;
                        lo_next         = ins_tally;
                    end
                end
                else if (!o_found_reg)
                begin
                    status_next = STS_UNKNOWN;
                    aff_next    = '0;
                    have_next   = 1'b0;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_REDUCE:
                        begin
                            if (qty_reg > o_rem_reg)
                            begin
                                status_next = STS_OVER;
                            end
                            else
                            begin
                                lvl_we   = old_found_reg;
                                lvl_wsum = red_sum;
                                ord_we   = 1'b1;
                                if (red_rem == '0)
                                begin
                                    ord_wdata       = '0;
                                    live_count_next = live_count_reg - 1'b1;
                                    lvl_wtally      = drop_tally;
                                    if (old_found_reg && (drop_tally == '0))
                                    begin
                                        level_live_next[old_idx_reg] = 1'b0;
                                    end
                                    if (drop_tally != '0)
                                    begin
                                        ls_next = red_sum;
                                        lo_next = drop_tally;
                                    end
                                end
                                else
                                begin
                                    ord_wdata  = '{live: 1'b1, key: ref_reg,
                                                   place: o_place_reg, rem: red_rem};
                                    lvl_wtally = old_tally_reg;
                                    ls_next    = red_sum;
                                    lo_next    = old_tally_reg;
                                end
                            end
                        end

                        CMD_DELETE:
                        begin
                            ord_we          = 1'b1;
                            ord_wdata       = '0;
                            live_count_next = live_count_reg - 1'b1;
                            lvl_we          = old_found_reg;
                            if (old_found_reg && (drop_tally == '0))
                            begin
                                level_live_next[old_idx_reg] = 1'b0;
                            end
                            if (drop_tally != '0)
                            begin
                                ls_next = drop_sum;
                                lo_next = drop_tally;
                            end
                        end

                        CMD_REPLACE:
                        begin
                            if (oth_found_reg && (oth_idx_reg != o_idx_reg))
                            begin
                                // the original goes away even though the new ref is taken
                                status_next     = STS_DUP_REF;
                                ord_we          = 1'b1;
                                ord_wdata       = '0;
                                live_count_next = live_count_reg - 1'b1;
                                lvl_we          = old_found_reg;
                                if (old_found_reg && (drop_tally == '0))
                                begin
                                    level_live_next[old_idx_reg] = 1'b0;
                                end
                            end
                            else if (!room)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                ord_we    = 1'b1;
                                ord_wdata = '{live: 1'b1, key: nref_reg, place: new_place,
                                              rem: qty_reg};
                                lvl_we    = old_found_reg;
                                if (same_place)
                                begin
                                    lvl_wsum   = rep_sum;
                                    lvl_wtally = old_tally_reg;
                                    ls_next    = rep_sum;
                                    lo_next    = old_tally_reg;
                                end
                                else
                                begin
                                    if (old_found_reg && (drop_tally == '0))
                                    begin
                                        level_live_next[old_idx_reg] = 1'b0;
                                    end
                                    l2_do_next = 1'b1;
                                    ls_next    = ins_sum;
                                    lo_next    = ins_tally;
                                end
                            end
                        end

                        default:
                        begin
                            status_next = STS_OK;
                        end
                    endcase
                end
            end

            S_EXEC2:
            begin
                if (l2_do_reg)
                begin
                    lvl_we     = 1'b1;
                    lvl_waddr  = l2_idx_reg;
                    lvl_wkey   = l2_key_reg;
                    lvl_wsum   = l2_sum_reg;
                    lvl_wtally = l2_tally_reg;
                    level_live_next[l2_idx_reg] = 1'b1;
                end
                l2_do_next = 1'b0;
                bv_next    = 1'b0;
                bb_next    = '0;
                av_next    = 1'b0;
                ba_next    = '0;
                cnt_next   = '0;
                state_next = S_BSCAN;
            end

            S_BSCAN:
            begin
                if ((cnt_reg != '0) && have_reg && level_live_reg[pidx_l] &&
                    (lvl_key_rd[PLACE_W-1:33] == aff_reg))
                begin
                    if (lvl_key_rd[32])
                    begin
                        if (!av_reg || (lvl_key_rd[31:0] < ba_reg))
                        begin
                            av_next = 1'b1;
                            ba_next = lvl_key_rd[31:0];
                        end
                    end
                    else
                    begin
                        if (!bv_reg || (lvl_key_rd[31:0] > bb_reg))
                        begin
                            bv_next = 1'b1;
                            bb_next = lvl_key_rd[31:0];
                        end
                    end
                end
                if (cnt_reg == SCW'(MAX_LEVELS))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b0, open_ext[CNT_OUT_W-1:0], lo_ext[CNT_OUT_W-1:0],
                                     ls_reg, ba_reg, av_reg, bb_reg, bv_reg, aff_reg,
                                     status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= CW'(MAX_ORDERS))
        else $error("live order count above table size");

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg == STS_UNKNOWN) |-> (aff_reg == '0 && !have_reg))
        else $error("unknown ref carries a stock");

    a_error_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg != STS_OK) |-> (ls_reg == '0 && lo_reg == '0))
        else $error("level fields set on an error");

    a_l2_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC2) |-> ($past(state_reg) == S_EXEC))
        else $error("second level write out of sequence");

endmodule : limit_order_book_update_top
`default_nettype wire
